// File: hw/rtl/triangle_unit_normal_defines.svh
// ---------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Checks that are compiled for simulation only and vanish for synthesis.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("triangle_unit_normal: check failed");
`define TUN_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("triangle_unit_normal: implication failed");
`else
`define TUN_ASSERT(lbl, cond)
`define TUN_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// File: hw/rtl/tun_pkg.sv
// ---------------------------------------------------------------------------
// Triangle unit normal package
// Widths and request types shared by the normal pipeline.
// ---------------------------------------------------------------------------
package tun_pkg;

	localparam int CoordW    = 16;
	localparam int DiffW     = CoordW + 1;
	localparam int ProdW     = 2 * DiffW;
	localparam int CrossW    = ProdW + 1;
	localparam int MagW      = CrossW - 1;
	localparam int TopW      = 6;
	localparam int NormTop   = 29;
	localparam int NormW     = NormTop + 1;
	localparam int SqW       = 2 * NormW;
	localparam int SumW      = SqW + 2;
	localparam int RootW     = SumW + 1;
	localparam int SqrtSteps = 32;
	localparam int LenW      = 32;
	localparam int FracW     = 14;
	localparam int QW        = FracW + 1;
	localparam int RemW      = LenW + QW - 1;
	localparam int OutW      = FracW + 2;
	localparam int DivStages = QW + 2;

	typedef struct packed {
		logic signed [CoordW-1:0] ax;
		logic signed [CoordW-1:0] ay;
		logic signed [CoordW-1:0] az;
		logic signed [CoordW-1:0] bx;
		logic signed [CoordW-1:0] by_coord;
		logic signed [CoordW-1:0] bz;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
	} tri_t;

	typedef struct packed {
		logic signed [OutW-1:0] nx;
		logic signed [OutW-1:0] ny;
		logic signed [OutW-1:0] nz;
		logic                   degenerate;
	} norm_t;

	typedef struct packed {
		logic [MagW-1:0] mx;
		logic [MagW-1:0] my;
		logic [MagW-1:0] mz;
		logic            sx;
		logic            sy;
		logic            sz;
	} mag_t;

	typedef struct packed {
		logic [NormW-1:0] mx;
		logic [NormW-1:0] my;
		logic [NormW-1:0] mz;
		logic             sx;
		logic             sy;
		logic             sz;
		logic             degen;
	} vec_t;

	typedef struct packed {
		logic [SumW-1:0] sum;
		vec_t            v;
	} sq_t;

	typedef struct packed {
		logic [LenW-1:0] len;
		vec_t            v;
	} len_t;

endpackage

// File: hw/rtl/tun_cross.sv
// ---------------------------------------------------------------------------
// Triangle unit normal cross product
// Edge differences, partial products and signed cross product in three stages.
// ---------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tri_valid,
	output logic tri_stall,
	input  tri_t tri_data,
	output logic mag_valid,
	input  logic mag_stall,
	output mag_t mag_data
);

	logic v_s1, v_s2, v_s3;
	logic st1, st2, st3;
	logic signed [DiffW-1:0] d1_s1 [3];
	logic signed [DiffW-1:0] d2_s1 [3];
	logic signed [ProdW-1:0] p_s2 [6];
	mag_t m_s3;
	logic signed [CrossW-1:0] cr [3];
	logic [MagW-1:0] mg [3];

	assign st3 = v_s3 & mag_stall;
	assign st2 = v_s2 & st3;
	assign st1 = v_s1 & st2;
	assign tri_stall = st1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= tri_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1) begin
			d1_s1[0] <= DiffW'(tri_data.ax) - DiffW'(tri_data.bx);
			d1_s1[1] <= DiffW'(tri_data.ay) - DiffW'(tri_data.by_coord);
			d1_s1[2] <= DiffW'(tri_data.az) - DiffW'(tri_data.bz);
			d2_s1[0] <= DiffW'(tri_data.bx) - DiffW'(tri_data.cx);
			d2_s1[1] <= DiffW'(tri_data.by_coord) - DiffW'(tri_data.cy);
			d2_s1[2] <= DiffW'(tri_data.bz) - DiffW'(tri_data.cz);
		end
		if (!st2) begin
			p_s2[0] <= ProdW'(d1_s1[1]) * ProdW'(d2_s1[2]);
			p_s2[1] <= ProdW'(d1_s1[2]) * ProdW'(d2_s1[1]);
			p_s2[2] <= ProdW'(d1_s1[2]) * ProdW'(d2_s1[0]);
			p_s2[3] <= ProdW'(d1_s1[0]) * ProdW'(d2_s1[2]);
			p_s2[4] <= ProdW'(d1_s1[0]) * ProdW'(d2_s1[1]);
			p_s2[5] <= ProdW'(d1_s1[1]) * ProdW'(d2_s1[0]);
		end
		if (!st3) m_s3 <= {mg[0], mg[1], mg[2], cr[0][CrossW-1], cr[1][CrossW-1],
			cr[2][CrossW-1]};
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = CrossW'(p_s2[2*i]) - CrossW'(p_s2[2*i+1]);
			mg[i] = cr[i][CrossW-1] ? MagW'(-cr[i]) : MagW'(cr[i]);
		end
	end

	assign mag_valid = v_s3;
	assign mag_data  = m_s3;

endmodule

// File: hw/rtl/tun_norm.sv
// ---------------------------------------------------------------------------
// Triangle unit normal scaling
// Common normalizing shift of the three magnitudes and their squared norm.
// ---------------------------------------------------------------------------
module tun_norm import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic mag_valid,
	output logic mag_stall,
	input  mag_t mag_data,
	output logic sq_valid,
	input  logic sq_stall,
	output sq_t  sq_data
);

	logic v_s4, v_s5, v_s6, v_s7;
	logic st4, st5, st6, st7;
	mag_t m_s4;
	logic [TopW-1:0] top_s4;
	logic zero_s4;
	vec_t vec_s5, vec_s6, vec_s7;
	logic [SqW-1:0] sq_s6 [3];
	logic [SumW-1:0] sum_s7;
	logic [MagW-1:0] any;
	logic [TopW-1:0] top;
	logic [MagW-1:0] mi [3];
	logic [NormW-1:0] mo [3];

	assign st7 = v_s7 & sq_stall;
	assign st6 = v_s6 & st7;
	assign st5 = v_s5 & st6;
	assign st4 = v_s4 & st5;
	assign mag_stall = st4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (!st4) v_s4 <= mag_valid;
			if (!st5) v_s5 <= v_s4;
			if (!st6) v_s6 <= v_s5;
			if (!st7) v_s7 <= v_s6;
		end
	end

	// The leading bit of the largest magnitude is the leading bit of their OR.
	always_comb begin
		any = mag_data.mx | mag_data.my | mag_data.mz;
		top = '0;
		for (int b = 0; b < MagW; b++) begin
			if (any[b]) top = TopW'(b);
		end
	end

	always_comb begin
		mi[0] = m_s4.mx;
		mi[1] = m_s4.my;
		mi[2] = m_s4.mz;
		for (int i = 0; i < 3; i++) begin
			if (top_s4 > TopW'(NormTop)) mo[i] = NormW'(mi[i] >> (top_s4 - TopW'(NormTop)));
			else mo[i] = NormW'(mi[i] << (TopW'(NormTop) - top_s4));
		end
	end

	always_ff @(posedge clk) begin
		if (!st4) begin
			m_s4    <= mag_data;
			top_s4  <= top;
			zero_s4 <= (any == '0);
		end
		if (!st5) vec_s5 <= {mo[0], mo[1], mo[2], m_s4.sx, m_s4.sy, m_s4.sz, zero_s4};
		if (!st6) begin
			vec_s6   <= vec_s5;
			sq_s6[0] <= SqW'(vec_s5.mx) * SqW'(vec_s5.mx);
			sq_s6[1] <= SqW'(vec_s5.my) * SqW'(vec_s5.my);
			sq_s6[2] <= SqW'(vec_s5.mz) * SqW'(vec_s5.mz);
		end
		if (!st7) begin
			vec_s7 <= vec_s6;
			sum_s7 <= SumW'(sq_s6[0]) + SumW'(sq_s6[1]) + SumW'(sq_s6[2]);
		end
	end

	assign sq_valid = v_s7;
	assign sq_data  = '{sum: sum_s7, v: vec_s7};

endmodule

// File: hw/rtl/tun_sqrt.sv
// ---------------------------------------------------------------------------
// Triangle unit normal square root
// Integer square root of the squared norm, one result bit per stage.
// ---------------------------------------------------------------------------
module tun_sqrt import tun_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic sq_valid,
	output logic sq_stall,
	input  sq_t  sq_data,
	output logic len_valid,
	input  logic len_stall,
	output len_t len_data
);

	logic [SqrtSteps-1:0] valid_s;
	logic [SqrtSteps-1:0] st;
	logic [RootW-1:0] x_s [SqrtSteps];
	logic [RootW-1:0] r_s [SqrtSteps];
	vec_t vec_s [SqrtSteps];

	assign st[SqrtSteps-1] = valid_s[SqrtSteps-1] & len_stall;
	assign sq_stall = st[0];

	for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
		logic [RootW-1:0] x_in, r_in, x_nx, r_nx, trial;
		logic v_in;
		vec_t p_in;
		localparam logic [RootW-1:0] Bit = RootW'(1) << (2 * (SqrtSteps - 1 - j));

		if (j == 0) begin : g_first
			assign x_in = RootW'(sq_data.sum);
			assign r_in = '0;
			assign v_in = sq_valid;
			assign p_in = sq_data.v;
		end else begin : g_next
			assign x_in = x_s[j-1];
			assign r_in = r_s[j-1];
			assign v_in = valid_s[j-1];
			assign p_in = vec_s[j-1];
		end
		if (j < SqrtSteps - 1) begin : g_chain
			assign st[j] = valid_s[j] & st[j+1];
		end

		always_comb begin
			trial = r_in + Bit;
			if (x_in >= trial) begin
				x_nx = x_in - trial;
				r_nx = (r_in >> 1) + Bit;
			end else begin
				x_nx = x_in;
				r_nx = r_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j] <= 1'b0;
			else if (!st[j]) valid_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (!st[j]) begin
				x_s[j]   <= x_nx;
				r_s[j]   <= r_nx;
				vec_s[j] <= p_in;
			end
		end
	end

	assign len_valid = valid_s[SqrtSteps-1];
	assign len_data  = '{len: LenW'(r_s[SqrtSteps-1]), v: vec_s[SqrtSteps-1]};

endmodule

// File: hw/rtl/tun_div.sv
// ---------------------------------------------------------------------------
// Triangle unit normal divider
// Rounded quotient of each magnitude by the length, one quotient bit per stage after the rounding stage.
// ---------------------------------------------------------------------------
module tun_div import tun_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  len_valid,
	output logic  len_stall,
	input  len_t  len_data,
	output logic  norm_valid,
	input  logic  norm_stall,
	output norm_t norm_data
);

	localparam int Steps = DivStages - 1;

	logic [Steps-1:0] valid_s;
	logic [Steps-1:0] st;
	logic [RemW-1:0] rem_s [Steps][3];
	logic [QW-1:0] q_s [Steps][3];
	logic [LenW-1:0] d_s [Steps];
	vec_t vec_s [Steps];
	logic out_v_q, out_st;
	norm_t out_q;
	logic [QW-1:0] qf [3];
	logic sg [3];
	logic [OutW-1:0] nv [3];

	assign out_st = out_v_q & norm_stall;
	assign st[Steps-1] = valid_s[Steps-1] & out_st;
	assign len_stall = st[0];

	for (genvar j = 0; j < Steps; j++) begin : g_stage
		logic [RemW-1:0] rem_nx [3];
		logic [QW-1:0] q_nx [3];
		logic v_in;
		vec_t p_in;
		logic [LenW-1:0] d_in;

		if (j == 0) begin : g_first
			// Adding half the divisor makes the truncating division round to nearest.
			assign v_in = len_valid;
			assign p_in = len_data.v;
			assign d_in = len_data.len;
			assign rem_nx[0] = (RemW'(len_data.v.mx) << FracW) + RemW'(len_data.len >> 1);
			assign rem_nx[1] = (RemW'(len_data.v.my) << FracW) + RemW'(len_data.len >> 1);
			assign rem_nx[2] = (RemW'(len_data.v.mz) << FracW) + RemW'(len_data.len >> 1);
			assign q_nx[0] = '0;
			assign q_nx[1] = '0;
			assign q_nx[2] = '0;
		end else begin : g_next
			localparam int B = QW - j;
			logic [RemW-1:0] t;

			assign v_in = valid_s[j-1];
			assign p_in = vec_s[j-1];
			assign d_in = d_s[j-1];
			assign t = RemW'(d_s[j-1]) << B;
			for (genvar k = 0; k < 3; k++) begin : g_lane
				assign rem_nx[k] = (rem_s[j-1][k] >= t) ? rem_s[j-1][k] - t : rem_s[j-1][k];
				assign q_nx[k] = (rem_s[j-1][k] >= t) ? (q_s[j-1][k] | (QW'(1) << B))
					: q_s[j-1][k];
			end
		end
		if (j < Steps - 1) begin : g_chain
			assign st[j] = valid_s[j] & st[j+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j] <= 1'b0;
			else if (!st[j]) valid_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (!st[j]) begin
				rem_s[j] <= rem_nx;
				q_s[j]   <= q_nx;
				d_s[j]   <= d_in;
				vec_s[j] <= p_in;
			end
		end
	end

	always_comb begin
		qf[0] = q_s[Steps-1][0];
		qf[1] = q_s[Steps-1][1];
		qf[2] = q_s[Steps-1][2];
		sg[0] = vec_s[Steps-1].sx;
		sg[1] = vec_s[Steps-1].sy;
		sg[2] = vec_s[Steps-1].sz;
		for (int k = 0; k < 3; k++) begin
			if (vec_s[Steps-1].degen) nv[k] = '0;
			else if (sg[k]) nv[k] = -OutW'(qf[k]);
			else nv[k] = OutW'(qf[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (!out_st) out_v_q <= valid_s[Steps-1];
	end

	always_ff @(posedge clk) begin
		if (!out_st) out_q <= {nv[0], nv[1], nv[2], vec_s[Steps-1].degen};
	end

	assign norm_valid = out_v_q;
	assign norm_data  = out_q;

endmodule

// File: hw/rtl/triangle_unit_normal.sv
// ---------------------------------------------------------------------------
// Triangle unit normal
// Unit normal of a triangle from its three corners.
// ---------------------------------------------------------------------------
// Takes one triangle request per cycle while tri_stall is low (three corners, signed Q8.8) and
// returns its unit normal (a-b) x (b-c) as signed Q1.14 components, passing
// through three stages for the cross product, four for the normalizing shift
// and squared norm, 32 for the bit-per-stage square root and 17 for the
// rounding stage, bit-per-stage division and output register. Every stage holds its
// request while the next one is stalled, and empty stages fill up behind a
// stalled output. A triangle whose cross product is zero returns a zero
// normal with degenerate set.
`include "triangle_unit_normal_defines.svh"
module triangle_unit_normal import tun_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tri_valid,
	output logic  tri_stall,
	input  tri_t  tri_data,
	output logic  norm_valid,
	input  logic  norm_stall,
	output norm_t norm_data
);

	logic mag_valid, mag_stall, sq_valid, sq_stall, len_valid, len_stall;
	mag_t mag_data;
	sq_t  sq_data;
	len_t len_data;

	tun_cross u_cross (
		.clk, .arst_n,
		.tri_valid, .tri_stall, .tri_data,
		.mag_valid, .mag_stall, .mag_data
	);

	tun_norm u_norm (
		.clk, .arst_n,
		.mag_valid, .mag_stall, .mag_data,
		.sq_valid, .sq_stall, .sq_data
	);

	tun_sqrt u_sqrt (
		.clk, .arst_n,
		.sq_valid, .sq_stall, .sq_data,
		.len_valid, .len_stall, .len_data
	);

	tun_div u_div (
		.clk, .arst_n,
		.len_valid, .len_stall, .len_data,
		.norm_valid, .norm_stall, .norm_data
	);

	`TUN_ASSERT_IMP(a_degen_zero, norm_valid && norm_data.degenerate, norm_data.nx == 0 && norm_data.ny == 0 && norm_data.nz == 0)
	`TUN_ASSERT_IMP(a_range, norm_valid, norm_data.nx >= -16384 && norm_data.nx <= 16384 && norm_data.ny >= -16384 && norm_data.ny <= 16384 && norm_data.nz >= -16384 && norm_data.nz <= 16384)
	`TUN_ASSERT_IMP(a_no_stall, !norm_stall, !tri_stall)
	`TUN_ASSERT_IMP(a_len_set, len_valid && !len_data.v.degen, len_data.len != 0)

endmodule

// File: test/triangle_unit_normal_tb.sv
// ---------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangle requests through a valid/stall handshake with random gaps
// and output stalls, and checks every normal against an in-bench predictor.
// ---------------------------------------------------------------------------
module triangle_unit_normal_tb import tun_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom = 800;
	localparam int DrainCycles = 80;
	localparam longint CycleLimit = 200000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  tri_valid = 1'b0;
	logic  tri_stall;
	tri_t  tri_data = '0;
	logic  norm_valid;
	logic  norm_stall = 1'b0;
	norm_t norm_data;

	norm_t  pending_normals[$];
	int     errors = 0;
	longint cycles = 0;
	bit     feeding_done = 1'b0;

	// One directed request: corners plus an optional typed-in expectation.
	typedef struct {
		tri_t  t;
		bit    fixed;
		norm_t n;
	} row_t;

	localparam logic signed [15:0] MaxC = 16'sh7fff;
	localparam logic signed [15:0] MinC = -16'sh8000;

	triangle_unit_normal dut (.*);

	always #10 clk = ~clk;

	// Integer square root, bit by bit, rounding down.
	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic norm_t unit_normal(tri_t t);
		longint d1[3], d2[3], cr[3];
		longint unsigned mag[3], maxm, sum, len, q;
		bit neg[3];
		int p;
		norm_t r;
		d1[0] = longint'(t.ax) - longint'(t.bx);
		d1[1] = longint'(t.ay) - longint'(t.by_coord);
		d1[2] = longint'(t.az) - longint'(t.bz);
		d2[0] = longint'(t.bx) - longint'(t.cx);
		d2[1] = longint'(t.by_coord) - longint'(t.cy);
		d2[2] = longint'(t.bz) - longint'(t.cz);
		cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
		cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
		cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
		maxm = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			mag[i] = neg[i] ? -cr[i] : cr[i];
			if (mag[i] > maxm)
				maxm = mag[i];
		end
		r = '0;
		if (maxm == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		p = -1;
		for (longint unsigned v = maxm; v != 0; v >>= 1)
			p++;
		for (int i = 0; i < 3; i++) begin
			if (p > NormTop)
				mag[i] >>= (p - NormTop);
			else
				mag[i] <<= (NormTop - p);
			sum += mag[i] * mag[i];
		end
		len = floor_root(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << FracW) + (len >> 1)) / len;
			if (neg[i])
				q = -q;
			case (i)
				0: r.nx = q[OutW-1:0];
				1: r.ny = q[OutW-1:0];
				default: r.nz = q[OutW-1:0];
			endcase
		end
		return r;
	endfunction

	function automatic tri_t corners(logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
		tri_t t;
		t.ax = ax; t.ay = ay; t.az = az;
		t.bx = bx; t.by_coord = by; t.bz = bz;
		t.cx = cx; t.cy = cy; t.cz = cz;
		return t;
	endfunction

	function automatic norm_t normal(logic signed [15:0] x, y, z, logic dg);
		norm_t n;
		n.nx = x; n.ny = y; n.nz = z; n.degenerate = dg;
		return n;
	endfunction

	function automatic tri_t random_triangle();
		tri_t t;
		int mode;
		mode = $urandom_range(0, 9);
		t = tri_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		if (mode < 3) begin
			// Small triangle near a random spot, typical mesh content.
			t.bx = t.ax + 16'($signed($urandom_range(0, 511)) - 256);
			t.by_coord = t.ay + 16'($signed($urandom_range(0, 511)) - 256);
			t.bz = t.az + 16'($signed($urandom_range(0, 511)) - 256);
			t.cx = t.ax + 16'($signed($urandom_range(0, 511)) - 256);
			t.cy = t.ay + 16'($signed($urandom_range(0, 511)) - 256);
			t.cz = t.az + 16'($signed($urandom_range(0, 511)) - 256);
		end else if (mode == 3) begin
			// Collinear corners: c lies on the line through a and b.
			t.bx = t.ax + 16'($signed($urandom_range(0, 63)) - 32);
			t.by_coord = t.ay + 16'($signed($urandom_range(0, 63)) - 32);
			t.bz = t.az + 16'($signed($urandom_range(0, 63)) - 32);
			t.cx = t.bx - (t.ax - t.bx);
			t.cy = t.by_coord - (t.ay - t.by_coord);
			t.cz = t.bz - (t.az - t.bz);
		end else if (mode == 4) begin
			t.ax = $urandom_range(0, 1) ? MaxC : MinC;
			t.cy = $urandom_range(0, 1) ? MaxC : MinC;
			t.bz = $urandom_range(0, 1) ? MaxC : MinC;
		end
		return t;
	endfunction

	task automatic send_triangle(tri_t t);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap != 0) begin
			tri_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_data <= t;
		tri_valid <= 1'b1;
		@(posedge clk);
		while (tri_stall)
			@(posedge clk);
		pending_normals.push_back(unit_normal(t));
	endtask

	// Output side stall pattern.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (wait_n != 0) begin
				norm_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			norm_stall <= 1'b0;
			@(posedge clk);
			while (!norm_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		norm_t want;
		if (arst_n && norm_valid && !norm_stall) begin
			if (pending_normals.size() == 0) begin
				errors++;
				$display("%0t: unexpected normal %p", $time, norm_data);
			end else begin
				want = pending_normals.pop_front();
				if (norm_data.nx !== want.nx)
					$display("%0t: nx expected %0d actual %0d", $time, want.nx, norm_data.nx);
				if (norm_data.ny !== want.ny)
					$display("%0t: ny expected %0d actual %0d", $time, want.ny, norm_data.ny);
				if (norm_data.nz !== want.nz)
					$display("%0t: nz expected %0d actual %0d", $time, want.nz, norm_data.nz);
				if (norm_data.degenerate !== want.degenerate)
					$display("%0t: degenerate expected %0b actual %0b", $time,
						want.degenerate, norm_data.degenerate);
				if (norm_data !== want)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("triangle_unit_normal_tb failed");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All corners coincident.
		rows.push_back('{corners(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, normal(0, 0, 0, 1)});
		rows.push_back('{corners(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC),
			1, normal(0, 0, 0, 1)});
		// Collinear along x.
		rows.push_back('{corners(MinC, 0, 0, 0, 0, 0, MaxC, 0, 0), 1, normal(0, 0, 0, 1)});
		// Axis-aligned triangles give exact unit normals.
		rows.push_back('{corners(256, 0, 0, 0, 0, 0, 0, -256, 0), 1, normal(0, 0, 16384, 0)});
		rows.push_back('{corners(0, 256, 0, 0, 0, 0, 0, 0, -256), 1, normal(16384, 0, 0, 0)});
		rows.push_back('{corners(0, 0, 256, 0, 0, 0, -256, 0, 0), 1, normal(0, 16384, 0, 0)});
		rows.push_back('{corners(0, -256, 0, 0, 0, 0, 0, 0, -256), 1, normal(-16384, 0, 0, 0)});
		// Extremes, checked by the predictor.
		rows.push_back('{corners(MaxC, MinC, MaxC, MinC, MaxC, MinC, MaxC, MaxC, MinC), 0, '0});
		rows.push_back('{corners(MinC, MinC, MinC, MaxC, MaxC, MaxC, MinC, MaxC, MinC), 0, '0});
		rows.push_back('{corners(MaxC, 0, 0, 0, MaxC, 0, 0, 0, MaxC), 0, '0});
		rows.push_back('{corners(MinC, 0, 0, 0, MinC, 0, 0, 0, MinC), 0, '0});
		rows.push_back('{corners(1, 0, 0, 0, 0, 0, 0, 1, 0), 0, '0});
		rows.push_back('{corners(-1, -1, -1, 0, 0, 0, 1, -1, 1), 0, '0});
		rows.push_back('{corners(100, 37, -5, 3, 3, 3, -77, 12, 900), 0, '0});
		rows.push_back('{corners(16'sh5555, -16'sh2aab, 16'sh1234, 16'sh7000, 16'sh0001,
			-16'sh4321, 16'sh0fff, -16'sh7ffe, 16'sh3333), 0, '0});

		foreach (rows[i]) begin
			r = rows[i];
			if (r.fixed && unit_normal(r.t) !== r.n) begin
				// The typed-in value is what the hardware must give; keep it.
				$display("%0t: row %0d expected %p predictor %p", $time, i, r.n,
					unit_normal(r.t));
				errors++;
			end
			send_triangle(r.t);
		end
		for (int i = 0; i < NumRandom; i++)
			send_triangle(random_triangle());
		tri_valid <= 1'b0;
		feeding_done = 1'b1;
	end

	initial begin
		wait (feeding_done);
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("triangle_unit_normal_tb passed");
		else
			$display("triangle_unit_normal_tb failed");
		$finish;
	end

endmodule
